/* rtl/core/ssds_pkg.sv */
// Shared types and constants for the scan-stream deframer and gray-level scaler.
package ssds_pkg;

  // Stream markers
  localparam logic [15:0] LINE_SYNC    = 16'hFEFA;
  localparam logic [15:0] FRAME_SYNC   = 16'hFEFB;
  localparam int          HEADER_WORDS = 5;
  localparam logic [10:0] ROW_TOP      = 11'd2047;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Register reset values
  localparam logic [10:0] WIDTH_RST  = 11'd768;
  localparam logic [10:0] HEIGHT_RST = 11'd1024;
  localparam logic [15:0] CAP_RST    = 16'd8192;

  // Field widths
  localparam int WORD_W = 16;
  localparam int CNT_W  = 11;
  localparam int ADDR_W = 20;
  localparam int IDX_W  = 10;
  localparam int GRAY_W = 8;
  localparam int PROD_W = 2 * CNT_W;
  localparam int NUM_W  = WORD_W + GRAY_W;

  // Result kinds
  typedef enum logic [1:0] {
    EV_PIXEL = 2'd0,
    EV_LINE  = 2'd1,
    EV_FRAME = 2'd2
  } ssds_event_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_CAP    = 2'd2
  } ssds_reg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_EMIT
  } ssds_state_t;

  // Status of the serial units
  typedef struct packed {
    logic div_busy;
    logic mul_busy;
  } ssds_unit_st_t;

endpackage

/* rtl/core/ssds_if.sv */
// Channel interfaces: stream input, result output and configuration write.
interface ssds_in_if;
  import ssds_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface ssds_out_if;
  import ssds_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic [ADDR_W-1:0] buffer_address;
  logic [IDX_W-1:0]  column_index;
  logic [IDX_W-1:0]  row_index;
  logic [GRAY_W-1:0] gray_level;
  logic [31:0]       packed_pixel;
  logic              row_wrapped;
  modport source (output valid, output event_kind, output buffer_address,
                  output column_index, output row_index, output gray_level,
                  output packed_pixel, output row_wrapped, input ready);
  modport sink   (input valid, input event_kind, input buffer_address,
                  input column_index, input row_index, input gray_level,
                  input packed_pixel, input row_wrapped, output ready);
endinterface

interface ssds_cfg_if;
  import ssds_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        index;
  logic [WORD_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/ssds_mul.sv */
// Bit-serial shift-add multiplier: prod = a * b + c, one bit of a per cycle.
module ssds_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ssds_pkg::CNT_W-1:0] a,
  input  logic [ssds_pkg::CNT_W-1:0] b,
  input  logic [ssds_pkg::CNT_W-1:0] c,
  output logic                       busy,
  output logic [ssds_pkg::PROD_W-1:0] prod
);
  import ssds_pkg::*;

  localparam logic [3:0] LAST = 4'(CNT_W - 1);

  logic              busy_r, busy_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  a_r, a_nxt;
  logic [PROD_W-1:0] b_r, b_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;

  // load, then one multiplier bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = a;
      b_nxt    = {{(PROD_W-CNT_W){1'b0}}, b};
      acc_nxt  = {{(PROD_W-CNT_W){1'b0}}, c};
    end else if (busy_r) begin
      if (a_r[0]) begin
        acc_nxt = acc_r + b_r;
      end
      a_nxt   = a_r >> 1;
      b_nxt   = b_r << 1;
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule

/* rtl/core/ssds_div.sv */
// Bit-serial restoring divider giving an 8-bit quotient clamped to 255.
module ssds_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ssds_pkg::NUM_W-1:0]  num,
  input  logic [ssds_pkg::WORD_W-1:0] den,
  output logic                        busy,
  output logic [ssds_pkg::GRAY_W-1:0] quot
);
  import ssds_pkg::*;

  localparam logic [3:0] LAST = 4'(GRAY_W);

  logic              busy_r, busy_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [WORD_W-1:0] den_r, den_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [GRAY_W-1:0] quo_r, quo_nxt;
  logic [WORD_W:0]   cur;

  // step 0 checks for clamp, steps 1..8 shift in one dividend bit each
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cur      = {rem_r, num_r[GRAY_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == '0) begin
        // quotient of 256 or more saturates
        if (num_r >= {den_r, {GRAY_W{1'b0}}}) begin
          quo_nxt  = '1;
          busy_nxt = 1'b0;
        end else begin
          rem_nxt = num_r[NUM_W-1:GRAY_W];
          quo_nxt = '0;
        end
      end else begin
        if (cur >= {1'b0, den_r}) begin
          rem_nxt = WORD_W'(cur - {1'b0, den_r});
          quo_nxt = {quo_r[GRAY_W-2:0], 1'b1};
        end else begin
          rem_nxt = cur[WORD_W-1:0];
          quo_nxt = {quo_r[GRAY_W-2:0], 1'b0};
        end
        num_nxt = num_r << 1;
        if (cnt_r == LAST) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign quot = quo_r;

endmodule

/* rtl/core/scan_stream_deframe_scale.sv */
// Top level: stream deframer, pixel scaler and frame-buffer write generator.
// Sync, header and out-of-width pixel words leave the sequencer idle. The header
// word that ends a header passes through the emit state, which loads the line or
// frame start into the output register. A pixel that produces a frame-buffer
// write passes through the launch, wait and emit states before the next word can
// be taken; the wait is set by the 11-step serial row*width multiplier (the
// serial divider runs alongside it in 9 steps or fewer). A finished result sits
// in an output register, so new words are accepted while it waits to be taken;
// the next result waits in the emit state until the register is taken. Effective
// width and height are the register values limited to MAX_WIDTH and MAX_HEIGHT.
module scan_stream_deframe_scale #(
  parameter int MAX_WIDTH  = ssds_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ssds_pkg::DEF_MAX_HEIGHT
) (
  input  logic      clk,
  input  logic      rst_n,
  ssds_in_if.sink   in_ch,
  ssds_out_if.source out_ch,
  ssds_cfg_if.sink  cfg_ch
);
  import ssds_pkg::*;

  localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);

  // configuration
  logic [CNT_W-1:0]  width_r, height_r;
  logic [WORD_W-1:0] cap_r;
  logic [CNT_W-1:0]  wid_eff, hgt_eff;

  // deframer state
  logic [2:0]        hl_r, hl_nxt;
  logic              fss_r, fss_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [WORD_W-1:0] peak_r, peak_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;

  // pending result
  ssds_event_t       rk_r, rk_nxt;
  logic [CNT_W-1:0]  rrow_r, rrow_nxt;
  logic [CNT_W-1:0]  rcol_r, rcol_nxt;
  logic              rwrap_r, rwrap_nxt;

  // sequencer
  ssds_state_t       state_r, state_nxt;
  logic              acc, start, load;
  ssds_unit_st_t     ust;

  // output register
  logic              ov_r, ov_nxt;
  ssds_event_t       ok_r;
  logic [ADDR_W-1:0] oaddr_r;
  logic [IDX_W-1:0]  ocol_r, orow_r;
  logic [GRAY_W-1:0] ogray_r;
  logic              owrap_r;

  logic [PROD_W-1:0] prod;
  logic [GRAY_W-1:0] quot;
  logic [NUM_W-1:0]  num;
  logic [WORD_W-1:0] w, pk;
  logic [CNT_W-1:0]  rw;
  logic              wr;

  assign wid_eff = ({2'b0, width_r} > MAXW) ? MAXW[CNT_W-1:0] : width_r;
  assign hgt_eff = ({2'b0, height_r} > MAXH) ? MAXH[CNT_W-1:0] : height_r;

  // configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      cap_r    <= CAP_RST;
    end else if (cfg_ch.valid) begin
      case (ssds_reg_t'(cfg_ch.index))
        REG_WIDTH:  width_r  <= cfg_ch.data[CNT_W-1:0];
        REG_HEIGHT: height_r <= cfg_ch.data[CNT_W-1:0];
        REG_CAP:    cap_r    <= cfg_ch.data;
        default:    ;
      endcase
    end
  end

  assign acc = in_ch.valid && in_ch.ready;
  assign w   = in_ch.data_word;

  // word decode and state update at acceptance
  always_comb begin
    hl_nxt    = hl_r;
    fss_nxt   = fss_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    peak_nxt  = peak_r;
    word_nxt  = word_r;
    rk_nxt    = rk_r;
    rrow_nxt  = rrow_r;
    rcol_nxt  = rcol_r;
    rwrap_nxt = rwrap_r;
    pk        = peak_r;
    rw        = row_r;
    wr        = 1'b0;
    if (acc) begin
      if (hl_r != '0) begin
        hl_nxt = hl_r - 3'd1;
        if (hl_r == 3'd1) begin
          col_nxt   = '0;
          rcol_nxt  = '0;
          rwrap_nxt = 1'b0;
          if (fss_r) begin
            row_nxt  = '0;
            rrow_nxt = '0;
            rk_nxt   = EV_FRAME;
          end else begin
            rw       = (row_r < ROW_TOP) ? row_r + 11'd1 : row_r;
            row_nxt  = rw;
            rrow_nxt = rw;
            rk_nxt   = EV_LINE;
          end
        end
      end else if (w == LINE_SYNC || w == FRAME_SYNC) begin
        hl_nxt  = 3'(HEADER_WORDS);
        fss_nxt = (w == FRAME_SYNC);
      end else begin
        // running maximum below the cap, never zero
        if (w > peak_r && w < cap_r) begin
          pk = w;
        end
        if (pk == '0) begin
          pk = 16'd1;
        end
        peak_nxt = pk;
        // row wrap
        if (row_r >= hgt_eff) begin
          rw = '0;
          wr = 1'b1;
        end
        row_nxt = rw;
        if (col_r < wid_eff) begin
          col_nxt   = col_r + 11'd1;
          rcol_nxt  = col_r;
          rrow_nxt  = rw;
          rwrap_nxt = wr;
          rk_nxt    = EV_PIXEL;
          word_nxt  = w;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r   <= '0;
      fss_r  <= 1'b0;
      col_r  <= '0;
      row_r  <= '0;
      peak_r <= '0;
    end else begin
      hl_r   <= hl_nxt;
      fss_r  <= fss_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      peak_r <= peak_nxt;
    end
    word_r  <= word_nxt;
    rk_r    <= rk_nxt;
    rrow_r  <= rrow_nxt;
    rcol_r  <= rcol_nxt;
    rwrap_r <= rwrap_nxt;
  end

  // word * 255 as (word << 8) - word
  assign num = {word_r, {GRAY_W{1'b0}}} - {{GRAY_W{1'b0}}, word_r};

  ssds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   (num),
    .den   (peak_r),
    .busy  (ust.div_busy),
    .quot  (quot)
  );

  ssds_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .a     (rrow_r),
    .b     (wid_eff),
    .c     (rcol_r),
    .busy  (ust.mul_busy),
    .prod  (prod)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (hl_r != '0) begin
            state_nxt = (hl_r == 3'd1) ? ST_EMIT : ST_IDLE;
          end else if (w != LINE_SYNC && w != FRAME_SYNC && col_r < wid_eff) begin
            state_nxt = ST_LAUNCH;
          end
        end
      end
      ST_LAUNCH: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (!ust.div_busy && !ust.mul_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    start       = 1'b0;
    load        = 1'b0;
    case (state_r)
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_LAUNCH: start = 1'b1;
      ST_WAIT:   ;
      ST_EMIT:   load = !ov_r || out_ch.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_comb begin
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    if (load) begin
      ok_r   <= rk_r;
      orow_r <= rrow_r[IDX_W-1:0];
      if (rk_r == EV_PIXEL) begin
        oaddr_r <= prod[ADDR_W-1:0];
        ocol_r  <= rcol_r[IDX_W-1:0];
        ogray_r <= quot;
        owrap_r <= rwrap_r;
      end else begin
        oaddr_r <= '0;
        ocol_r  <= '0;
        ogray_r <= '0;
        owrap_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.event_kind     = ok_r;
  assign out_ch.buffer_address = oaddr_r;
  assign out_ch.column_index   = ocol_r;
  assign out_ch.row_index      = orow_r;
  assign out_ch.gray_level     = ogray_r;
  assign out_ch.packed_pixel   = {4{ogray_r}};
  assign out_ch.row_wrapped    = owrap_r;

`ifndef SYNTHESIS
  // no word is taken while a serial unit still works on a pixel
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> !ust.div_busy && !ust.mul_busy)
    else $error("word accepted while serial unit busy");

  // header countdown never exceeds the header length
  a_hl_range: assert property (@(posedge clk) disable iff (!rst_n)
    hl_r <= 3'(HEADER_WORDS))
    else $error("header count out of range");

  // both units have finished before a result is loaded
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !ust.div_busy && !ust.mul_busy)
    else $error("result loaded while unit busy");

  // line and frame starts carry zero payload
  a_sync_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ok_r != EV_PIXEL) |->
      (oaddr_r == '0 && ocol_r == '0 && ogray_r == '0 && !owrap_r))
    else $error("nonzero payload on line or frame start");

  // the unit start follows a launch only
  a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> state_r == ST_WAIT)
    else $error("launch not followed by wait");
`endif

endmodule
